[hw/rtl/scpa_pkg.sv]
// ----------------------------------------------------------------------------
// Size class pool allocator package
// Shared constants and the command type passed from front end to back end.
// ----------------------------------------------------------------------------
package scpa_pkg;
	localparam int GRANULE_BYTES  = 32;
	localparam int CLASS_COUNT    = 16;
	localparam int ARENA_GRANULES = 2048;
	localparam int GRAN_W         = $clog2(ARENA_GRANULES);
	localparam int GSHIFT         = $clog2(GRANULE_BYTES);
	localparam int CLS_W          = 5;
	localparam int CIDX_W         = 4;
	localparam int LIM_W          = 12;
	localparam int HDR_BYTES      = 16;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_TOOBIG  = 2'd2;
	localparam logic [1:0] ST_BADFREE = 2'd3;

	typedef enum logic [1:0] {
		K_RESULT = 2'd0,
		K_ALLOC  = 2'd1,
		K_FREE   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [CLS_W-1:0]   cls;
		logic [GRAN_W-1:0]  gran;
		logic [1:0]         status;
	} cmd_t;

	typedef struct packed {
		logic               empty;
		logic [GRAN_W-1:0]  gran;
	} link_t;
endpackage

[hw/rtl/size_class_pool_allocator.sv]
// ----------------------------------------------------------------------------
// Size class pool allocator
// Segregated free-list allocator over a fixed arena of granules.
// ----------------------------------------------------------------------------
// Too-large, null and malformed requests and carving are finished from S_READY;
// a list pop or a free passes through S_WAIT as well because the link or tag
// memory read is registered. A new item is taken only in S_READY while the
// result register is free. After reset the tag memory is cleared in S_CLEAR
// before the first item is carried out; meanwhile the queue accepts up to two items.
module size_class_pool_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // request_bytes [15:0], block_address [31:16]
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // payload_address [15:0], size_class [20:16], status [22:21]
);
	import scpa_pkg::*;

	cmd_t push_cmd;
	cmd_t pop_cmd;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	logic clearing_ready;

	scpa_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (clearing_ready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	assign s_tready = clearing_ready;

	scpa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_cmd    (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_cmd    (pop_cmd)
	);

	scpa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.q_not_empty (q_not_empty),
		.q_cmd       (pop_cmd),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);
endmodule

[hw/rtl/scpa_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module scpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[hw/rtl/scpa_front.sv]
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts requests, works out the size class or the freed granule, and
// resolves requests that need no state as finished results.
// ----------------------------------------------------------------------------
module scpa_front (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,
	input  logic               s_tuser,
	input  logic               q_full,
	output logic               q_push,
	output scpa_pkg::cmd_t     q_cmd
);
	import scpa_pkg::*;

	logic [15:0] bytes;
	logic [15:0] addr;
	logic [17:0] rounded;
	logic [12:0] cls_w;
	logic [15:0] off;

	assign bytes    = s_tdata[15:0];
	assign addr     = s_tdata[31:16];
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign rounded  = {2'b00, bytes} + 18'(HDR_BYTES + GRANULE_BYTES - 1);
	assign cls_w    = 13'(rounded >> GSHIFT);
	assign off      = addr - 16'(HDR_BYTES);

	always_comb begin
		q_cmd.kind   = K_RESULT;
		q_cmd.cls    = '0;
		q_cmd.gran   = '0;
		q_cmd.status = ST_OK;
		if (!s_tuser) begin
			if (cls_w > 13'(CLASS_COUNT)) begin
				q_cmd.status = ST_TOOBIG;
			end else begin
				q_cmd.kind = K_ALLOC;
				q_cmd.cls  = cls_w[CLS_W-1:0];
			end
		end else if (addr == 16'd0) begin
			q_cmd.status = ST_OK;
		end else if (addr < 16'(HDR_BYTES) || off[GSHIFT-1:0] != '0
				|| (off >> GSHIFT) >= 16'(ARENA_GRANULES)) begin
			q_cmd.status = ST_BADFREE;
		end else begin
			q_cmd.kind = K_FREE;
			q_cmd.gran = GRAN_W'(off >> GSHIFT);
		end
	end
endmodule

[hw/rtl/scpa_fifo.sv]
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module scpa_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scpa_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output scpa_pkg::cmd_t rd_cmd
);
	import scpa_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign rd_cmd    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule

[hw/rtl/scpa_back.sv]
// ----------------------------------------------------------------------------
// Allocator back end
// Holds the class list heads, the link and tag memories and the bump
// pointer, carries out allocations and frees, and drives the result register.
// ----------------------------------------------------------------------------
module scpa_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [scpa_pkg::LIM_W-1:0]  cfg_wdata,
	input  logic                        q_not_empty,
	input  scpa_pkg::cmd_t              q_cmd,
	output logic                        q_pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [23:0]                 m_tdata
);
	import scpa_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_READY = 3'b010,
		S_WAIT  = 3'b100
	} state_t;

	state_t            state_q;
	logic [GRAN_W-1:0] clr_q;
	link_t             head_q [CLASS_COUNT];
	logic [LIM_W-1:0]  carve_q;
	logic [LIM_W-1:0]  limit_q;
	cmd_t              cur_q;
	logic              out_valid_q;
	logic [15:0]       out_addr_q;
	logic [CLS_W-1:0]  out_cls_q;
	logic [1:0]        out_st_q;

	logic              out_free;
	logic              issue;
	logic [CIDX_W-1:0] q_idx;
	logic [LIM_W-1:0]  lim_eff;
	logic [LIM_W:0]    carve_end;
	logic              link_we;
	logic [GRAN_W-1:0] link_waddr;
	link_t             link_wdata;
	logic              link_re;
	link_t             link_rdata;
	logic              tag_we;
	logic [GRAN_W-1:0] tag_waddr;
	logic [CLS_W-1:0]  tag_wdata;
	logic              tag_re;
	logic [CLS_W-1:0]  tag_rdata;
	logic [CIDX_W-1:0] tag_idx;
	logic [CIDX_W-1:0] cur_idx;
	logic              tag_ok;

	assign out_free  = !out_valid_q || m_tready;
	assign issue     = state_q == S_READY && q_not_empty && out_free;
	assign q_pop     = issue;
	assign q_idx     = CIDX_W'(q_cmd.cls - CLS_W'(1));
	assign cur_idx   = CIDX_W'(cur_q.cls - CLS_W'(1));
	assign tag_idx   = CIDX_W'(tag_rdata - CLS_W'(1));
	assign tag_ok    = tag_rdata != '0 && tag_rdata <= CLS_W'(CLASS_COUNT);
	assign lim_eff   = (limit_q > LIM_W'(ARENA_GRANULES)) ? LIM_W'(ARENA_GRANULES) : limit_q;
	assign carve_end = {1'b0, carve_q} + (LIM_W+1)'(q_cmd.cls);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {1'b0, out_st_q, out_cls_q, out_addr_q};

	assign link_re    = issue && q_cmd.kind == K_ALLOC && !head_q[q_idx].empty;
	assign link_we    = state_q == S_WAIT && cur_q.kind == K_FREE && tag_ok;
	assign link_waddr = cur_q.gran;
	assign link_wdata = head_q[tag_idx];
	assign tag_re     = issue && q_cmd.kind == K_FREE;

	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = clr_q;
		tag_wdata = '0;
		if (state_q == S_CLEAR) begin
			tag_we = 1'b1;
		end else if (issue && q_cmd.kind == K_ALLOC && head_q[q_idx].empty
				&& carve_end <= {1'b0, lim_eff}) begin
			tag_we    = 1'b1;
			tag_waddr = GRAN_W'(carve_q);
			tag_wdata = q_cmd.cls;
		end
	end

	scpa_ram #(.WIDTH(GRAN_W + 1), .DEPTH(ARENA_GRANULES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (head_q[q_idx].gran),
		.rdata (link_rdata)
	);

	scpa_ram #(.WIDTH(CLS_W), .DEPTH(ARENA_GRANULES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.re    (tag_re),
		.raddr (q_cmd.gran),
		.rdata (tag_rdata)
	);

	always_ff @(posedge clk) begin
		if (issue) begin
			cur_q <= q_cmd;
			if (q_cmd.kind == K_ALLOC) begin
				cur_q.gran <= head_q[q_idx].gran;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			carve_q     <= '0;
			limit_q     <= LIM_W'(ARENA_GRANULES);
			out_valid_q <= 1'b0;
			out_addr_q  <= '0;
			out_cls_q   <= '0;
			out_st_q    <= ST_OK;
			for (int i = 0; i < CLASS_COUNT; i++) begin
				head_q[i] <= '{empty: 1'b1, gran: '0};
			end
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + GRAN_W'(1);
					if (clr_q == GRAN_W'(ARENA_GRANULES - 1)) begin
						state_q <= S_READY;
					end
				end
				S_READY: begin
					if (issue) begin
						case (q_cmd.kind)
							K_ALLOC: begin
								if (!head_q[q_idx].empty) begin
									state_q <= S_WAIT;
								end else begin
									out_valid_q <= 1'b1;
									out_cls_q   <= q_cmd.cls;
									if (carve_end > {1'b0, lim_eff}) begin
										out_addr_q <= '0;
										out_st_q   <= ST_NOSPACE;
									end else begin
										carve_q    <= carve_end[LIM_W-1:0];
										out_addr_q <= {carve_q[GRAN_W-1:0], GSHIFT'(HDR_BYTES)};
										out_st_q   <= ST_OK;
									end
								end
							end
							K_FREE: begin
								state_q <= S_WAIT;
							end
							default: begin
								out_valid_q <= 1'b1;
								out_addr_q  <= '0;
								out_cls_q   <= '0;
								out_st_q    <= q_cmd.status;
							end
						endcase
					end
				end
				S_WAIT: begin
					state_q     <= S_READY;
					out_valid_q <= 1'b1;
					if (cur_q.kind == K_ALLOC) begin
						head_q[cur_idx] <= link_rdata;
						out_addr_q      <= {cur_q.gran, GSHIFT'(HDR_BYTES)};
						out_cls_q       <= cur_q.cls;
						out_st_q        <= ST_OK;
					end else begin
						out_addr_q <= '0;
						if (tag_ok) begin
							head_q[tag_idx] <= '{empty: 1'b0, gran: cur_q.gran};
							out_cls_q       <= tag_rdata;
							out_st_q        <= ST_OK;
						end else begin
							out_cls_q <= '0;
							out_st_q  <= ST_BADFREE;
						end
					end
				end
				default: begin
					state_q <= S_READY;
				end
			endcase
		end
	end
endmodule
